// ===== rtl/cspi_pkg.sv =====
// Shared types and constants for the clock sync PI supervisor.
// Used by cspi_servo_core and clock_sync_pi_supervisor_top; no dependencies.
package cspi_pkg;

  // Default number of fraction bits in the Q format gains.
  localparam int GAIN_FRAC_BITS_DEF = 24;

  // Integrator limit in units of 1e-7 and the one second reset threshold.
  localparam longint RATE_SCALE    = 64'd10000000;
  localparam longint ONE_SECOND_NS = 64'd1000000000;

  // Configuration register byte addresses.
  localparam logic [3:0] ADDR_MAX_OFFSET = 4'h0;
  localparam logic [3:0] ADDR_PROP_GAIN  = 4'h4;
  localparam logic [3:0] ADDR_INTEG_GAIN = 4'h8;
  localparam logic [3:0] ADDR_SCHED_EN   = 4'hC;

  // Supervisor state codes.
  localparam logic [1:0] MODE_DISABLED = 2'd0;
  localparam logic [1:0] MODE_ARMED    = 2'd1;
  localparam logic [1:0] MODE_RUNNING  = 2'd2;

  // Schedule command codes.
  localparam logic [1:0] CMD_NONE  = 2'd0;
  localparam logic [1:0] CMD_START = 2'd1;
  localparam logic [1:0] CMD_STOP  = 2'd2;

  // Input beat.
  typedef struct packed {
    logic signed [32:0] offset_ns;
    logic               before_start_time;
    logic               engine_running;
  } in_item_t;

  // Output beat.
  typedef struct packed {
    logic               reset_cmd;
    logic               rate_valid;
    logic signed [31:0] rate_adj;
    logic               offset_fault;
    logic [1:0]         sched_cmd;
    logic [1:0]         sched_state;
  } out_item_t;

  // Per-item decisions taken from the input beat before the state update.
  typedef struct packed {
    logic fault;
    logic far;
    logic in_half;
    logic pre_start;
    logic running;
  } step_flags_t;

  // Control results of the state update.
  typedef struct packed {
    logic       reset_cmd;
    logic       rate_valid;
    logic       offset_fault;
    logic [1:0] sched_cmd;
    logic [1:0] sched_state;
  } step_res_t;

endpackage

// ===== rtl/cspi_servo_core.sv =====
// Servo state: integrator with clamp, pending reset flag and the schedule supervisor.
// Depends on cspi_pkg.
module cspi_servo_core
  import cspi_pkg::*;
#(
  parameter int GAIN_FRAC_BITS = GAIN_FRAC_BITS_DEF,
  localparam int INTEG_W = GAIN_FRAC_BITS + 26
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      step,
  input  step_flags_t               flags,
  input  logic signed [62:0]        integ_prod,
  input  logic                      sched_en,
  output step_res_t                 res,
  output logic signed [INTEG_W-1:0] integ_out
);

  localparam logic signed [63:0] ILIM = 64'(RATE_SCALE) <<< GAIN_FRAC_BITS;

  logic signed [INTEG_W-1:0] integrator;
  logic signed [INTEG_W-1:0] integrator_next;
  logic                      reset_pending;
  logic                      reset_pending_next;
  logic [1:0]                mode;
  logic [1:0]                mode_next;
  logic [1:0]                cmd;
  logic signed [INTEG_W-1:0] base;
  logic signed [63:0]        acc;

  // A pending reset clears the integrator before the step uses it.
  assign base = reset_pending ? '0 : integrator;
  assign acc  = 64'(base) + 64'(integ_prod);

  // Integrate and clamp on unfaulted steps.
  always_comb begin
    integrator_next = base;
    if (!flags.fault) begin
      if (acc > ILIM) begin
        integrator_next = INTEG_W'(ILIM);
      end else if (acc < -ILIM) begin
        integrator_next = INTEG_W'(-ILIM);
      end else begin
        integrator_next = acc[INTEG_W-1:0];
      end
    end
  end

  // A fault keeps the request and may raise it; a clean step clears it.
  assign reset_pending_next = flags.fault ? (reset_pending | flags.far) : 1'b0;

  // Schedule supervisor, run only on clean steps when enabled.
  always_comb begin
    mode_next = mode;
    cmd       = CMD_NONE;
    if (!flags.fault && sched_en) begin
      case (mode)
        MODE_ARMED: begin
          if (reset_pending) begin
            cmd       = CMD_STOP;
            mode_next = MODE_DISABLED;
          end else if (!flags.pre_start) begin
            mode_next = flags.running ? MODE_RUNNING : MODE_DISABLED;
          end
        end
        MODE_RUNNING: begin
          if (reset_pending) begin
            cmd       = CMD_STOP;
            mode_next = MODE_DISABLED;
          end else if (!flags.running) begin
            mode_next = MODE_DISABLED;
          end
        end
        default: begin
          mode_next = MODE_DISABLED;
          if (!reset_pending && flags.in_half) begin
            cmd       = CMD_START;
            mode_next = MODE_ARMED;
          end
        end
      endcase
    end
  end

  // Results of this step, registered by the caller.
  assign res.reset_cmd    = reset_pending;
  assign res.rate_valid   = !flags.fault;
  assign res.offset_fault = flags.fault;
  assign res.sched_cmd    = cmd;
  assign res.sched_state  = mode_next;
  assign integ_out        = integrator_next;

  // State registers advance once per item.
  always_ff @(posedge clk) begin
    if (rst) begin
      integrator    <= '0;
      reset_pending <= 1'b1;
      mode          <= MODE_DISABLED;
    end else if (step) begin
      integrator    <= integrator_next;
      reset_pending <= reset_pending_next;
      mode          <= mode_next;
    end
  end

endmodule

// ===== rtl/clock_sync_pi_supervisor_top.sv =====
// Clock sync PI servo with anti-windup and schedule supervisor, top level.
// Depends on cspi_pkg and cspi_servo_core.
//
// Usage:
//   Input channel in_valid/in_stall/in_data carries one offset beat per sync
//   tick; output channel out_valid/out_stall/out_data returns one result beat
//   for each input beat, in order.
//   The APB-style port writes max_offset_ns (0x0), prop_gain (0x4),
//   integ_gain (0x8) and gate_sched_enabled (0xC); write it only while idle.
//   Throughput: one beat per cycle while the output is not stalled.
//   Four register stages: input, gain products, servo state update and
//   output. The servo state loops (integrator add and clamp, reset flag,
//   supervisor mode) each close within one stage.
//   When the receiver stalls, the output holds and earlier stages keep
//   filling until all four are occupied; only then is in_stall raised.
//   Reset clears the pipeline, loads the register defaults, zeroes the
//   integrator, marks a clock reset as pending and disables the supervisor.
module clock_sync_pi_supervisor_top
  import cspi_pkg::*;
#(
  parameter int GAIN_FRAC_BITS = GAIN_FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int INTEG_W = GAIN_FRAC_BITS + 26;
  localparam logic signed [33:0] SEC_POS = 34'(ONE_SECOND_NS);
  localparam logic signed [63:0] ADJ_MAX = 64'sd2147483647;
  localparam logic signed [63:0] ADJ_MIN = -64'sd2147483648;

  // Configuration registers.
  logic [29:0]        max_offset_ns;
  logic signed [31:0] prop_gain;
  logic signed [31:0] integ_gain;
  logic               gate_sched_enabled;
  logic               cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_offset_ns      <= 30'd1000000;
      prop_gain          <= '0;
      integ_gain         <= '0;
      gate_sched_enabled <= 1'b0;
    end else if (cfg_wr) begin
      case (paddr)
        ADDR_MAX_OFFSET: max_offset_ns      <= pwdata[29:0];
        ADDR_PROP_GAIN:  prop_gain          <= pwdata;
        ADDR_INTEG_GAIN: integ_gain         <= pwdata;
        ADDR_SCHED_EN:   gate_sched_enabled <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Register read back.
  always_comb begin
    case (paddr)
      ADDR_MAX_OFFSET: prdata = {2'b00, max_offset_ns};
      ADDR_PROP_GAIN:  prdata = prop_gain;
      ADDR_INTEG_GAIN: prdata = integ_gain;
      ADDR_SCHED_EN:   prdata = {31'd0, gate_sched_enabled};
      default:         prdata = '0;
    endcase
  end

  // Pipeline stage registers and valids.
  in_item_t                  in1;
  logic                      v1;
  step_flags_t               flags2;
  logic signed [62:0]        pp2;
  logic signed [62:0]        pq2;
  logic                      v2;
  step_res_t                 res3;
  logic signed [62:0]        pp3;
  logic signed [INTEG_W-1:0] integ3;
  logic                      v3;

  logic in_load;
  logic s2_load;
  logic s3_load;
  logic out_load;

  // Each stage moves forward when the next one is empty or emptying.
  assign out_load = v3 & (!out_valid | !out_stall);
  assign s3_load  = v2 & (!v3 | out_load);
  assign s2_load  = v1 & (!v2 | s3_load);
  assign in_stall = v1 & !s2_load;
  assign in_load  = in_valid & !in_stall;

  // Stage one: limit compares and the two gain products.
  logic signed [33:0] off34;
  logic signed [33:0] lim_pos;
  logic signed [33:0] half_pos;
  logic signed [30:0] off31;
  logic signed [62:0] prod_p;
  logic signed [62:0] prod_q;
  step_flags_t        flags1;

  assign off34    = 34'(in1.offset_ns);
  assign lim_pos  = signed'({4'd0, max_offset_ns});
  assign half_pos = signed'({5'd0, max_offset_ns[29:1]});
  // Unfaulted offsets are below 2^30 in magnitude, so 31 bits carry them.
  assign off31    = in1.offset_ns[30:0];
  assign prod_p   = off31 * prop_gain;
  assign prod_q   = off31 * integ_gain;

  assign flags1.fault     = (off34 >= lim_pos) || (off34 <= -lim_pos);
  assign flags1.far       = (off34 >= SEC_POS) || (off34 <= -SEC_POS);
  assign flags1.in_half   = (off34 > -half_pos) && (off34 < half_pos);
  assign flags1.pre_start = in1.before_start_time;
  assign flags1.running   = in1.engine_running;

  // Stage two: servo state update.
  step_res_t                 res_core;
  logic signed [INTEG_W-1:0] integ_core;

  cspi_servo_core #(
    .GAIN_FRAC_BITS(GAIN_FRAC_BITS)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .step       (s3_load),
    .flags      (flags2),
    .integ_prod (pq2),
    .sched_en   (gate_sched_enabled),
    .res        (res_core),
    .integ_out  (integ_core)
  );

  // Stage three: sum, truncate toward zero, negate and saturate.
  logic signed [63:0] sum;
  logic signed [63:0] floor_q;
  logic signed [63:0] adj_wide;
  logic signed [31:0] adj_sat;
  logic               low_nz;

  assign sum      = 64'(pp3) + 64'(integ3);
  assign floor_q  = sum >>> GAIN_FRAC_BITS;
  assign low_nz   = |sum[GAIN_FRAC_BITS-1:0];
  assign adj_wide = (sum[63] && low_nz) ? ~floor_q : -floor_q;

  always_comb begin
    if (adj_wide > ADJ_MAX) begin
      adj_sat = ADJ_MAX[31:0];
    end else if (adj_wide < ADJ_MIN) begin
      adj_sat = ADJ_MIN[31:0];
    end else begin
      adj_sat = adj_wide[31:0];
    end
  end

  // Valid flags of the pipeline.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v1        <= in_load | (v1 & !s2_load);
      v2        <= s2_load | (v2 & !s3_load);
      v3        <= s3_load | (v3 & !out_load);
      out_valid <= out_load | (out_valid & out_stall);
    end
  end

  // Payload registers of each stage.
  always_ff @(posedge clk) begin
    if (in_load) begin
      in1 <= in_data;
    end
    if (s2_load) begin
      flags2 <= flags1;
      pp2    <= prod_p;
      pq2    <= prod_q;
    end
    if (s3_load) begin
      res3   <= res_core;
      pp3    <= pp2;
      integ3 <= integ_core;
    end
    if (out_load) begin
      out_data.reset_cmd    <= res3.reset_cmd;
      out_data.rate_valid   <= res3.rate_valid;
      out_data.rate_adj     <= res3.rate_valid ? adj_sat : '0;
      out_data.offset_fault <= res3.offset_fault;
      out_data.sched_cmd    <= res3.sched_cmd;
      out_data.sched_state  <= res3.sched_state;
    end
  end

endmodule
